### sv/scdc_pkg.sv
// Package: types and constants for the slot clock drift compensator.
package scdc_pkg;

    localparam logic [15:0] SLOT_TICKS_RST   = 16'd328;
    localparam logic [3:0]  ACCURACY_RST     = 4'd1;
    localparam logic [15:0] KEEPALIVE_RST    = 16'd66;
    localparam logic [15:0] LEARN_RST        = 16'd58;

    localparam logic [1:0] CFG_SLOT_TICKS = 2'd0;
    localparam logic [1:0] CFG_ACCURACY   = 2'd1;
    localparam logic [1:0] CFG_KEEPALIVE  = 2'd2;
    localparam logic [1:0] CFG_BASE_THR   = 2'd3;

    localparam logic [1:0] MODE_SYNC     = 2'd0;
    localparam logic [1:0] MODE_SLOT     = 2'd1;
    localparam logic [1:0] MODE_COMPOUND = 2'd2;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_FAST = 2'd1;
    localparam logic [1:0] DIR_SLOW = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] time_correction;
        logic [63:0]        source_addr;
        logic               is_synced;
        logic [39:0]        current_asn;
        logic [15:0]        slot_count;
    } t_in;

    typedef struct packed {
        logic        set_period;
        logic [15:0] slot_period;
        logic [1:0]  drift_state;
        logic [15:0] interval_slots;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_DIV, ST_COUNT, ST_KMUL, ST_DONE
    } t_state;

    // divider control
    typedef struct packed {
        logic        start;
        logic [19:0] dividend;
        logic [15:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [19:0] quot;
    } t_div_rsp;

endpackage

### sv/scdc_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module scdc_divider import scdc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic [19:0] r_quot, n_quot;
    logic [16:0] r_rem, n_rem;
    logic [15:0] r_den, n_den;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [16:0] w_trial;
    logic [17:0] w_diff;

    // one shift and subtract step
    always_comb begin
        w_trial = {r_rem[15:0], r_quot[19]};
        w_diff  = {1'b0, w_trial} - {2'b0, r_den};
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_den   = r_den;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_req.start) begin
            n_quot = i_req.dividend;
            n_rem  = '0;
            n_den  = i_req.divisor;
            n_cnt  = 5'd20;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_diff[17]) begin
                n_rem  = w_diff[16:0];
                n_quot = {r_quot[18:0], 1'b1};
            end else begin
                n_rem  = w_trial;
                n_quot = {r_quot[18:0], 1'b0};
            end
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_den  <= n_den;
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

`ifndef ASSERT_OFF
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without busy");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_req.start) |=> (r_busy || r_done))
        else $error("divider dropped busy");
    a_cnt_zero_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_cnt == 5'd0)) else $error("divider count left over");
`endif
endmodule

### sv/slot_clock_drift_compensator_unit.sv
// Top level: slot clock drift compensator with sequencer and divider.
// Accept to result: single slot, unused mode and non-learning sync pass COUNT, DONE.
// Learning sync passes COUNT, MUL, DIV (divide), DONE; a zero divisor starts no divide.
// Compound item passes COUNT, KMUL, DONE; the countdown loop counts one slot a cycle.
// Next item taken the cycle after its result is registered; a stalled result holds only DONE.
// Synchronous active-low reset loads register defaults and clears all drift state.
module slot_clock_drift_compensator_unit import scdc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    t_state r_state, n_state;
    t_in    r_item, n_item;
    logic [15:0] r_slot_ticks, r_keepalive;
    logic [3:0]  r_accuracy;
    logic [1:0]  r_dir, n_dir;
    logic [15:0] r_countdown, n_countdown, r_interval, n_interval;
    logic [15:0] r_applied, n_applied, r_corr_sum, n_corr_sum;
    logic [15:0] r_learn_thr, n_learn_thr;
    logic [39:0] r_last_asn, n_last_asn;
    logic [63:0] r_source_id, n_source_id;
    logic [15:0] r_elapsed, n_elapsed, r_divisor, n_divisor;
    logic [15:0] r_left, n_left, r_k, n_k;
    logic        r_set, n_set;
    logic [15:0] r_period, n_period;
    logic        r_out_valid, n_out_valid;
    t_out        r_out, n_out;
    t_div_req    w_div_req;
    t_div_rsp    w_div_rsp;
    logic        w_in_acc, w_cfg_acc, w_out_free;
    logic [39:0] w_diff;
    logic [15:0] w_sat_elapsed, w_part, w_abs;
    logic [16:0] w_dbl;
    logic [31:0] w_base_prod;
    logic [19:0] w_kacc;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    scdc_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // datapath helpers
    always_comb begin
        w_diff        = r_item.current_asn - r_last_asn;
        w_sat_elapsed = (w_diff > 40'hFFFF) ? 16'hFFFF : w_diff[15:0];
        w_part        = r_item.time_correction + r_corr_sum;
        w_abs         = -r_item.time_correction;
        w_dbl         = {r_learn_thr, 1'b0};
        w_base_prod   = r_slot_ticks * ({16'd0, r_item.slot_count} + 32'd1);
        w_kacc        = r_k * r_accuracy;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_in_acc) n_state = ST_COUNT;
            ST_COUNT: begin
                if (r_item.mode == MODE_SYNC) begin
                    n_state = ST_DONE;
                    if (r_learn_thr <= r_keepalive && r_item.is_synced &&
                        r_item.source_addr == r_source_id && w_sat_elapsed > r_learn_thr)
                        n_state = ST_MUL;
                end else if (r_item.mode == MODE_COMPOUND) begin
                    if (r_left == 16'd0 || r_countdown == 16'd0 || r_dir == DIR_NONE)
                        n_state = ST_KMUL;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_MUL:  n_state = ST_DIV;
            ST_DIV:  if (w_div_rsp.done || r_divisor == 16'd0) n_state = ST_DONE;
            ST_KMUL: n_state = ST_DONE;
            ST_DONE: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_item = r_item;  n_dir = r_dir;  n_countdown = r_countdown;
        n_interval = r_interval;  n_applied = r_applied;  n_corr_sum = r_corr_sum;
        n_learn_thr = r_learn_thr;  n_last_asn = r_last_asn;  n_source_id = r_source_id;
        n_elapsed = r_elapsed;  n_divisor = r_divisor;
        n_left = r_left;  n_k = r_k;  n_set = r_set;  n_period = r_period;
        n_out_valid = r_out_valid;  n_out = r_out;
        w_div_req = '0;
        if (r_out_valid && !i_out_stall) n_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_item = i_in_data;
                    n_left = i_in_data.slot_count;
                    n_k = '0;
                    n_set = 1'b0;
                    n_period = '0;
                end
            end
            ST_COUNT: begin
                if (r_item.mode == MODE_SYNC) begin
                    if (r_learn_thr <= r_keepalive) begin
                        if (r_item.is_synced && r_item.source_addr == r_source_id) begin
                            if (w_sat_elapsed > r_learn_thr) begin
                                n_elapsed = w_sat_elapsed;
                                n_last_asn = r_item.current_asn;
                                n_learn_thr = w_dbl[16] ? 16'hFFFF : w_dbl[15:0];
                                if (r_dir == DIR_NONE) begin
                                    if (r_item.time_correction > 16'sd1) begin
                                        n_dir = DIR_FAST;
                                        n_divisor = r_item.time_correction;
                                    end else if (r_item.time_correction < -16'sd1) begin
                                        n_dir = DIR_SLOW;
                                        n_divisor = w_abs;
                                    end else begin
                                        n_divisor = '0;
                                    end
                                end else if (r_dir == DIR_SLOW) begin
                                    n_divisor = r_applied - w_part;
                                end else begin
                                    n_divisor = r_applied + w_part;
                                end
                                n_applied = '0;
                                n_corr_sum = '0;
                            end else begin
                                n_corr_sum = w_part;
                            end
                        end else begin
                            n_dir = DIR_NONE;
                            n_countdown = '0;
                            n_applied = '0;
                            n_last_asn = r_item.current_asn;
                            n_source_id = r_item.source_addr;
                        end
                    end
                end else if (r_item.mode == MODE_SLOT) begin
                    if (r_dir != DIR_NONE && r_countdown != 16'd0) begin
                        n_countdown = r_countdown - 16'd1;
                        if (r_countdown == 16'd1) begin
                            n_countdown = r_interval;
                            n_set = 1'b1;
                            n_applied = r_applied + {12'd0, r_accuracy};
                            n_period = (r_dir == DIR_SLOW) ? r_slot_ticks - r_accuracy
                                                           : r_slot_ticks + r_accuracy;
                        end
                    end
                end else if (r_item.mode == MODE_COMPOUND) begin
                    // one slot counted per cycle
                    if (r_left != 16'd0 && r_countdown != 16'd0 && r_dir != DIR_NONE) begin
                        n_left = r_left - 16'd1;
                        n_countdown = r_countdown - 16'd1;
                        if (r_countdown == 16'd1) begin
                            n_countdown = r_interval;
                            n_k = r_k + 16'd1;
                        end
                    end
                end
            end
            ST_MUL: begin
                w_div_req.start    = (r_divisor != 16'd0);
                w_div_req.dividend = r_accuracy * r_elapsed;
                w_div_req.divisor  = r_divisor;
            end
            ST_DIV: begin
                if (r_divisor == 16'd0) begin
                    n_countdown = r_interval;
                end else if (w_div_rsp.done) begin
                    n_interval  = (w_div_rsp.quot > 20'hFFFF) ? 16'hFFFF
                                                              : w_div_rsp.quot[15:0];
                    n_countdown = n_interval;
                end
            end
            ST_KMUL: begin
                if (r_k != 16'd0) begin
                    n_set = 1'b1;
                    n_applied = r_applied + w_kacc[15:0];
                    n_period = (r_dir == DIR_SLOW) ? w_base_prod[15:0] - w_kacc[15:0]
                                                   : w_base_prod[15:0] + w_kacc[15:0];
                end
            end
            ST_DONE: begin
                // wait here while the previous result is still held
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out.set_period     = r_set;
                    n_out.slot_period    = r_set ? r_period : 16'd0;
                    n_out.drift_state    = r_dir;
                    n_out.interval_slots = r_interval;
                end
            end
            default: ;
        endcase
        if (w_cfg_acc && i_cfg_index == CFG_BASE_THR) n_learn_thr = i_cfg_data;
    end

    // registers
    always_ff @(posedge i_clk) begin
        r_item <= n_item;  r_elapsed <= n_elapsed;  r_divisor <= n_divisor;
        r_left <= n_left;  r_k <= n_k;
        r_set <= n_set;  r_period <= n_period;  r_out <= n_out;
        if (!i_rst_n) begin
            r_state <= ST_IDLE;  r_out_valid <= 1'b0;
            r_slot_ticks <= SLOT_TICKS_RST;  r_accuracy <= ACCURACY_RST;
            r_keepalive <= KEEPALIVE_RST;
            r_dir <= DIR_NONE;  r_countdown <= '0;  r_interval <= '0;
            r_applied <= '0;  r_corr_sum <= '0;  r_learn_thr <= LEARN_RST;
            r_last_asn <= '0;  r_source_id <= '0;
        end else begin
            r_state <= n_state;  r_out_valid <= n_out_valid;
            r_dir <= n_dir;  r_countdown <= n_countdown;  r_interval <= n_interval;
            r_applied <= n_applied;  r_corr_sum <= n_corr_sum;
            r_learn_thr <= n_learn_thr;  r_last_asn <= n_last_asn;
            r_source_id <= n_source_id;
            if (w_cfg_acc) begin
                unique case (i_cfg_index)
                    CFG_SLOT_TICKS: r_slot_ticks <= i_cfg_data;
                    CFG_ACCURACY:   r_accuracy   <= i_cfg_data[3:0];
                    CFG_KEEPALIVE:  r_keepalive  <= i_cfg_data;
                    CFG_BASE_THR:   ;  // loads the learn threshold in the datapath block
                    default: ;
                endcase
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_in_stall) else $error("ready while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("result changed under stall");
    a_done_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && w_out_free) |=> r_out_valid)
        else $error("result not presented");
    a_period_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.set_period) |-> (r_out.slot_period == 16'd0))
        else $error("period without set");
`endif
endmodule

### tb/tb.sv
// Testbench: slot clock drift compensator, directed table then random traffic vs. predictor.
`timescale 1ns / 100ps

module tb;
    import scdc_pkg::*;

    typedef struct {
        int   cfg_sel;   // config set applied before this row, -1 for none
        t_in  item;
        logic typed;     // expected result given in the row
        t_out exp;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in         in_data;
    logic        out_valid;
    logic        out_stall;
    t_out        out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // predictor copy of registers and drift state
    logic [15:0] m_slot_ticks;
    logic [3:0]  m_accuracy;
    logic [15:0] m_keepalive;
    logic [1:0]  m_dir;
    logic [15:0] m_countdown;
    logic [15:0] m_interval;
    logic [15:0] m_applied;
    logic [15:0] m_corr_sum;
    logic [15:0] m_learn_thr;
    logic [39:0] m_last_asn;
    logic [63:0] m_source;

    t_out        pending_q[$];
    int          errors = 0;
    int          burst_left = 0;
    logic [63:0] cur_src;
    logic [39:0] cur_asn;
    logic [15:0] cfg_sets [7][4];
    t_row        rows[$];

    slot_clock_drift_compensator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // interval = accuracy * elapsed / divisor, zero divisor keeps the old one
    function automatic void learn_interval(logic [31:0] elapsed, logic [31:0] divisor);
        logic [31:0] q;
        if (divisor != 0) begin
            q = (32'(m_accuracy) * elapsed) / divisor;
            m_interval = (q > 32'hFFFF) ? 16'hFFFF : q[15:0];
        end
    endfunction

    function automatic void predict_sync(t_in it);
        logic [39:0] diff;
        logic [31:0] elapsed;
        logic [31:0] thr2;
        logic [15:0] part;
        logic signed [31:0] corr;
        if (m_learn_thr > m_keepalive) return;
        if (it.is_synced && it.source_addr == m_source) begin
            diff = it.current_asn - m_last_asn;
            elapsed = (diff > 40'hFFFF) ? 32'hFFFF : 32'(diff[15:0]);
            if (elapsed > 32'(m_learn_thr)) begin
                corr = 32'(it.time_correction);
                part = it.time_correction + m_corr_sum;
                if (m_dir == DIR_NONE) begin
                    if (corr > 1) begin
                        m_dir = DIR_FAST;
                        learn_interval(elapsed, corr);
                    end else if (corr < -1) begin
                        m_dir = DIR_SLOW;
                        learn_interval(elapsed, -corr);
                    end
                end else if (m_dir == DIR_SLOW) begin
                    learn_interval(elapsed, 32'(16'(m_applied - part)));
                end else begin
                    learn_interval(elapsed, 32'(16'(m_applied + part)));
                end
                m_countdown = m_interval;
                thr2 = 32'(m_learn_thr) * 2;
                m_applied = 16'd0;
                m_corr_sum = 16'd0;
                m_learn_thr = (thr2 > 32'hFFFF) ? 16'hFFFF : thr2[15:0];
                m_last_asn = it.current_asn;
            end else begin
                m_corr_sum = m_corr_sum + it.time_correction;
            end
        end else begin
            m_dir = DIR_NONE;
            m_countdown = 16'd0;
            m_applied = 16'd0;
            m_last_asn = it.current_asn;
            m_source = it.source_addr;
        end
    endfunction

    // period stretched or shortened by the given ticks
    function automatic logic [15:0] shift_period(logic [15:0] base, logic [15:0] ticks);
        m_applied = m_applied + ticks;
        return (m_dir == DIR_SLOW) ? base - ticks : base + ticks;
    endfunction

    function automatic t_out predict_drift(t_in it);
        t_out r;
        logic [15:0] k;
        logic [31:0] n;
        r = '0;
        k = '0;
        n = 32'(it.slot_count);
        if (it.mode == MODE_SYNC) begin
            predict_sync(it);
        end else if (it.mode == MODE_SLOT) begin
            if (m_dir != DIR_NONE && m_countdown != 0) begin
                m_countdown = m_countdown - 1;
                if (m_countdown == 0) begin
                    r.slot_period = shift_period(m_slot_ticks, 16'(m_accuracy));
                    r.set_period = 1'b1;
                    m_countdown = m_interval;
                end
            end
        end else if (it.mode == MODE_COMPOUND) begin
            if (m_dir != DIR_NONE && m_countdown != 0 && n != 0) begin
                for (int i = 0; i < n && m_countdown != 0; i++) begin
                    m_countdown = m_countdown - 1;
                    if (m_countdown == 0) begin
                        k++;
                        m_countdown = m_interval;
                    end
                end
                if (k != 0) begin
                    r.slot_period = shift_period(16'(32'(m_slot_ticks) * (n + 1)),
                                                 16'(32'(k) * 32'(m_accuracy)));
                    r.set_period = 1'b1;
                end
            end
        end
        r.drift_state = m_dir;
        r.interval_slots = m_interval;
        return r;
    endfunction

    // one config transaction; valid is lowered by the caller
    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        case (idx)
            CFG_SLOT_TICKS: m_slot_ticks = val;
            CFG_ACCURACY:   m_accuracy = val[3:0];
            CFG_KEEPALIVE:  m_keepalive = val;
            CFG_BASE_THR:   m_learn_thr = val;
        endcase
        @(negedge i_clk);
    endtask

    // drain results, then load a full register set
    task automatic load_config(int sel);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        @(negedge i_clk);
        write_reg(CFG_SLOT_TICKS, cfg_sets[sel][0]);
        write_reg(CFG_ACCURACY, cfg_sets[sel][1]);
        write_reg(CFG_KEEPALIVE, cfg_sets[sel][2]);
        write_reg(CFG_BASE_THR, cfg_sets[sel][3]);
        cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // sends one item in bursts with random gaps; returns at a falling edge
    task automatic send_item(t_in it, logic typed, t_out exp);
        t_out p;
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (in_stall);
        p = predict_drift(it);
        pending_q.push_back(typed ? exp : p);
        burst_left--;
        @(negedge i_clk);
    endtask

    function automatic t_in make_item(logic [1:0] mode, logic [15:0] corr, logic [63:0] src,
                                      logic syn, logic [39:0] asn, logic [15:0] cnt);
        t_in it;
        it.mode = mode;
        it.time_correction = corr;
        it.source_addr = src;
        it.is_synced = syn;
        it.current_asn = asn;
        it.slot_count = cnt;
        return it;
    endfunction

    function automatic t_out make_res(logic s, logic [15:0] p, logic [1:0] d, logic [15:0] iv);
        t_out r;
        r.set_period = s;
        r.slot_period = p;
        r.drift_state = d;
        r.interval_slots = iv;
        return r;
    endfunction

    function automatic void add_row(int sel, t_in it, logic typed, t_out exp);
        t_row r;
        r.cfg_sel = sel;
        r.item = it;
        r.typed = typed;
        r.exp = exp;
        rows.push_back(r);
    endfunction

    function automatic logic [15:0] pick_corr();
        int c;
        c = $urandom_range(0, 9);
        if (c < 2) return 16'd0;
        if (c < 5) return 16'($urandom_range(2, 30));
        if (c < 8) return -16'($urandom_range(2, 30));
        if (c < 9) return 16'($urandom_range(0, 2)) - 16'd1;
        return 16'($urandom);
    endfunction

    // random item: mostly well-formed sync and slot traffic on one source
    function automatic t_in rand_item(ref int big_left);
        int c;
        logic [31:0] adv;
        c = $urandom_range(0, 99);
        if (c < 10) begin
            return make_item(2'($urandom_range(0, 3)), 16'($urandom),
                             {$urandom, $urandom}, 1'($urandom), {8'($urandom), $urandom},
                             16'($urandom_range(0, 255)));
        end else if (c < 14) begin
            cur_src = {$urandom, $urandom};
            cur_asn = {8'($urandom), $urandom};
            return make_item(MODE_SYNC, pick_corr(), cur_src, 1'($urandom), cur_asn, '0);
        end else if (c < 38) begin
            adv = $urandom_range(0, 32'(m_learn_thr) * 2 + 4);
            if (adv > 70000) adv = 70000;
            cur_asn = cur_asn + 40'(adv);
            return make_item(MODE_SYNC, pick_corr(), cur_src, 1'b1, cur_asn,
                             16'($urandom));
        end else if (c < 86) begin
            return make_item(MODE_SLOT, 16'($urandom), {$urandom, $urandom}, 1'($urandom),
                             {8'($urandom), $urandom}, 16'($urandom));
        end else begin
            if (big_left > 0 && $urandom_range(0, 80) == 0) begin
                big_left--;
                return make_item(MODE_COMPOUND, '0, '0, 1'b0, '0, 16'hFFFF);
            end
            return make_item(MODE_COMPOUND, '0, '0, 1'b0, '0, 16'($urandom_range(0, 40)));
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_q.size() == 0) begin
                $display("%0t: result with none expected: %p", $time, out_data);
                errors++;
            end else begin
                e = pending_q.pop_front();
                if (out_data.set_period !== e.set_period) begin
                    $display("%0t: set_period exp %0d got %0d", $time,
                             e.set_period, out_data.set_period);
                    errors++;
                end
                if (out_data.slot_period !== e.slot_period) begin
                    $display("%0t: slot_period exp %0d got %0d", $time,
                             e.slot_period, out_data.slot_period);
                    errors++;
                end
                if (out_data.drift_state !== e.drift_state) begin
                    $display("%0t: drift_state exp %0d got %0d", $time,
                             e.drift_state, out_data.drift_state);
                    errors++;
                end
                if (out_data.interval_slots !== e.interval_slots) begin
                    $display("%0t: interval_slots exp %0d got %0d", $time,
                             e.interval_slots, out_data.interval_slots);
                    errors++;
                end
            end
        end
    end

    // receiver stall: segments with no, light, half or heavy stalling
    int stall_kind = 0;
    int stall_cnt = 0;
    always @(negedge i_clk) begin
        if (stall_cnt == 0) begin
            stall_kind = $urandom_range(0, 3);
            stall_cnt = $urandom_range(10, 80);
        end
        stall_cnt--;
        case (stall_kind)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= 1'($urandom_range(0, 1));
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    initial begin
        int big_left;
        t_out z;
        t_in it;
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        big_left = 3;
        cur_src = 64'd7;
        cur_asn = 40'd0;
        z = '0;

        // slot, accuracy, keepalive, base threshold
        cfg_sets[0] = '{16'd328, 16'd1, 16'd66, 16'd58};
        cfg_sets[1] = '{16'd328, 16'd1, 16'd65535, 16'd58};
        cfg_sets[2] = '{16'd65535, 16'd15, 16'd65535, 16'd1};
        cfg_sets[3] = '{16'd1, 16'd15, 16'd1000, 16'd20};
        cfg_sets[4] = '{16'd1000, 16'd7, 16'd1, 16'd1};
        cfg_sets[5] = '{16'd500, 16'd3, 16'd65535, 16'd65535};
        cfg_sets[6] = '{16'd328, 16'd1, 16'd66, 16'd58};

        // predictor reset state
        m_slot_ticks = SLOT_TICKS_RST;
        m_accuracy = ACCURACY_RST;
        m_keepalive = KEEPALIVE_RST;
        m_learn_thr = LEARN_RST;
        m_dir = DIR_NONE;
        m_countdown = '0;
        m_interval = '0;
        m_applied = '0;
        m_corr_sum = '0;
        m_last_asn = '0;
        m_source = '0;

        // reset defaults: idle, unused mode, new source with wrapped asn, frozen learning
        add_row(-1, make_item(MODE_SLOT, '0, '0, 1'b0, '0, '0), 1, z);
        add_row(-1, make_item(MODE_COMPOUND, '0, '0, 1'b0, '0, 16'hFFFF), 1, z);
        add_row(-1, make_item(2'd3, '1, '1, 1'b1, '1, '1), 1, z);
        add_row(-1, make_item(MODE_SYNC, '0, '1, 1'b0, '1, '0), 1, z);
        add_row(-1, make_item(MODE_SYNC, 16'h7FFF, '1, 1'b1, 40'd10, '0), 1, z);
        add_row(-1, make_item(MODE_SYNC, 16'h8000, '1, 1'b1, 40'd20, '0), 1, z);
        add_row(-1, make_item(MODE_SYNC, 16'd1, '1, 1'b1, 40'd200, '0), 1, z);
        add_row(-1, make_item(MODE_SYNC, 16'd9, '1, 1'b1, 40'd900, '0), 1, z);
        // learning enabled: fast drift, expiries, zero divisor, slow drift
        add_row(1, make_item(MODE_SYNC, '0, 64'd1, 1'b0, 40'd1000, '0), 1, z);
        add_row(-1, make_item(MODE_SYNC, 16'd5, 64'd1, 1'b1, 40'd1100, '0), 1,
                make_res(0, 0, DIR_FAST, 16'd20));
        add_row(-1, make_item(MODE_COMPOUND, '0, '0, 1'b0, '0, 16'd19), 0, z);
        add_row(-1, make_item(MODE_SLOT, '0, '0, 1'b0, '0, '0), 1,
                make_res(1, 16'd329, DIR_FAST, 16'd20));
        add_row(-1, make_item(MODE_COMPOUND, '0, '0, 1'b0, '0, 16'd45), 1,
                make_res(1, 16'd15090, DIR_FAST, 16'd20));
        add_row(-1, make_item(MODE_SYNC, -16'd3, 64'd1, 1'b1, 40'd1217, '0), 1,
                make_res(0, 0, DIR_FAST, 16'd20));
        add_row(-1, make_item(MODE_SYNC, 16'd7, 64'd1, 1'b1, 40'd1227, '0), 0, z);
        add_row(-1, make_item(MODE_SYNC, 16'd1, 64'd1, 1'b1, 40'd1517, '0), 0, z);
        add_row(-1, make_item(MODE_SYNC, '0, 64'd2, 1'b1, 40'd5000, '0), 0, z);
        add_row(-1, make_item(MODE_SYNC, -16'd10, 64'd2, 1'b1, 40'd6000, '0), 1,
                make_res(0, 0, DIR_SLOW, 16'd100));
        add_row(-1, make_item(MODE_COMPOUND, '0, '0, 1'b0, '0, 16'd100), 1,
                make_res(1, 16'd33127, DIR_SLOW, 16'd100));
        add_row(-1, make_item(MODE_SLOT, '0, '0, 1'b0, '0, '0), 0, z);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        foreach (rows[i]) begin
            if (rows[i].cfg_sel >= 0) load_config(rows[i].cfg_sel);
            send_item(rows[i].item, rows[i].typed, rows[i].exp);
        end

        // random phases, one per register set 1 to 6
        for (int ph = 1; ph < 7; ph++) begin
            load_config(ph);
            cur_src = {$urandom, $urandom};
            cur_asn = {8'($urandom), $urandom};
            send_item(make_item(MODE_SYNC, '0, cur_src, 1'b0, cur_asn, '0), 0, z);
            for (int n = 0; n < 190; n++) begin
                it = rand_item(big_left);
                send_item(it, 0, z);
            end
        end

        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
